/* rtl/process_ready_queue_macros.svh */
// Assertion helpers for the ready queue. Clock and reset names are fixed.
`ifndef PROCESS_READY_QUEUE_MACROS_SVH
`define PROCESS_READY_QUEUE_MACROS_SVH

// Same-cycle implication.
`define PRQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PRQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/prq_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package prq_pkg;

  localparam int unsigned DefaultDepth = 64;
  localparam int unsigned IdW          = 32;

  typedef enum logic [2:0] {
    ReqEnq  = 3'd0,
    ReqDeq  = 3'd1,
    ReqFind = 3'd2,
    ReqCtx  = 3'd3,
    ReqDel  = 3'd4
  } req_e;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StMiss     = 2'd1,
    StFull     = 2'd2,
    StMismatch = 2'd3
  } status_e;

  typedef struct packed {
    logic [IdW-1:0] id;
    logic [IdW-1:0] ctx;
  } entry_t;

endpackage

`default_nettype wire

/* rtl/process_ready_queue.sv */
// Enqueue, unused codes and refused requests go from the input beat straight to the
// result state; a search scans entries from the head until a hit or the end; dequeue and
// delete check the entry, then shift the entries behind it towards the head.
// Throughput: one request at a time; the single memory port pair sets the scan
// and shift pace of one entry per cycle. Reset clears the count, the sequencer and
// the result registers; slots stay unwritten and no clearing pass runs.
`timescale 1ns / 1ps
`default_nettype none

`include "process_ready_queue_macros.svh"

module process_ready_queue #(
  parameter int unsigned DEPTH = prq_pkg::DefaultDepth
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic [2:0]               req_type_i,
  input  wire logic [prq_pkg::IdW-1:0]  process_id_i,
  input  wire logic [prq_pkg::IdW-1:0]  context_tag_i,
  input  wire logic [5:0]               position_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic [1:0]                    status_o,
  output logic [5:0]                    found_position_o,
  output logic [prq_pkg::IdW-1:0]       out_id_o,
  output logic [prq_pkg::IdW-1:0]       out_context_o,
  output logic [6:0]                    entry_total_o,
  output logic                          not_empty_o,
  output logic [prq_pkg::IdW-1:0]       head_id_o
);

  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned CMPW = (CW > 6) ? CW : 6;
  localparam int unsigned PW   = (AW > 6) ? AW : 6;
  localparam int unsigned XW   = (CW > 7) ? CW : 7;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SHIFT,
    S_SCAN,
    S_DONE
  } state_e;

  // Entry store
  prq_pkg::entry_t mem [DEPTH];
  prq_pkg::entry_t rdata_q;
  logic            rd_en, wr_en;
  logic [AW-1:0]   rd_addr, wr_addr;
  prq_pkg::entry_t wr_data;

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rdata_q <= mem[rd_addr];
  end

  state_e                    state_q, state_d;
  prq_pkg::req_e             req_q, req_d;
  logic [prq_pkg::IdW-1:0]   pid_q, pid_d;
  logic [prq_pkg::IdW-1:0]   ctx_q, ctx_d;
  logic [AW-1:0]             idx_q, idx_d;
  logic [CW-1:0]             count_q, count_d;
  logic [prq_pkg::IdW-1:0]   head_q, head_d;
  prq_pkg::status_e          res_status_q, res_status_d;
  logic [AW-1:0]             res_pos_q, res_pos_d;
  prq_pkg::entry_t           res_entry_q, res_entry_d;

  logic                      out_valid_q, out_valid_d;
  logic [1:0]                status_q, status_d;
  logic [5:0]                fpos_q, fpos_d;
  logic [prq_pkg::IdW-1:0]   oid_q, oid_d;
  logic [prq_pkg::IdW-1:0]   octx_q, octx_d;
  logic [6:0]                total_q, total_d;
  logic                      nempty_q, nempty_d;
  logic [prq_pkg::IdW-1:0]   ohead_q, ohead_d;

  logic                      in_fire;
  logic [CW-1:0]             nxt, nxt2;
  logic                      hit;
  logic [PW-1:0]             pos_x;
  logic [XW-1:0]             cnt_x;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign nxt        = CW'(idx_q) + CW'(1);
  assign nxt2       = nxt + CW'(1);
  assign hit        = (req_q == prq_pkg::ReqFind) ? (rdata_q.id == pid_q)
                                                  : (rdata_q.ctx == ctx_q);
  assign pos_x      = PW'(res_pos_q);
  assign cnt_x      = XW'(count_q);

  always_comb begin
    state_d      = state_q;
    req_d        = req_q;
    pid_d        = pid_q;
    ctx_d        = ctx_q;
    idx_d        = idx_q;
    count_d      = count_q;
    head_d       = head_q;
    res_status_d = res_status_q;
    res_pos_d    = res_pos_q;
    res_entry_d  = res_entry_q;
    out_valid_d  = out_valid_q;
    status_d     = status_q;
    fpos_d       = fpos_q;
    oid_d        = oid_q;
    octx_d       = octx_q;
    total_d      = total_q;
    nempty_d     = nempty_q;
    ohead_d      = ohead_q;
    rd_en        = 1'b0;
    rd_addr      = '0;
    wr_en        = 1'b0;
    wr_addr      = idx_q;
    wr_data      = rdata_q;

    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          req_d        = prq_pkg::req_e'(req_type_i);
          pid_d        = process_id_i;
          ctx_d        = context_tag_i;
          idx_d        = '0;
          res_status_d = prq_pkg::StOk;
          res_pos_d    = '0;
          res_entry_d  = '0;
          state_d      = S_DONE;
          unique case (prq_pkg::req_e'(req_type_i))
            prq_pkg::ReqEnq: begin
              if (count_q == CW'(DEPTH)) begin
                res_status_d = prq_pkg::StFull;
              end else begin
                wr_en   = 1'b1;
                wr_addr = AW'(count_q);
                wr_data = '{id: process_id_i, ctx: context_tag_i};
                if (count_q == '0) head_d = process_id_i;
                count_d = count_q + CW'(1);
              end
            end
            prq_pkg::ReqDeq: begin
              if (count_q == '0) begin
                res_status_d = prq_pkg::StMiss;
              end else begin
                rd_en   = 1'b1;
                state_d = S_CHECK;
              end
            end
            prq_pkg::ReqFind, prq_pkg::ReqCtx: begin
              if (count_q == '0) begin
                res_status_d = prq_pkg::StMiss;
              end else begin
                rd_en   = 1'b1;
                state_d = S_SCAN;
              end
            end
            prq_pkg::ReqDel: begin
              if (CMPW'(position_i) >= CMPW'(count_q)) begin
                res_status_d = prq_pkg::StMiss;
              end else begin
                idx_d   = AW'(position_i);
                rd_en   = 1'b1;
                rd_addr = AW'(position_i);
                state_d = S_CHECK;
              end
            end
            default: ;
          endcase
        end
      end

      S_CHECK: begin
        res_pos_d   = idx_q;
        res_entry_d = rdata_q;
        if (req_q == prq_pkg::ReqDel && rdata_q.id != pid_q) begin
          res_status_d = prq_pkg::StMismatch;
          state_d      = S_DONE;
        end else if (nxt < count_q) begin
          // read the follower so that it can refill the removed slot
          rd_en   = 1'b1;
          rd_addr = AW'(nxt);
          state_d = S_SHIFT;
        end else begin
          count_d = count_q - CW'(1);
          state_d = S_DONE;
        end
      end

      S_SHIFT: begin
        wr_en = 1'b1;
        if (idx_q == '0) head_d = rdata_q.id;
        if (nxt2 < count_q) begin
          rd_en   = 1'b1;
          rd_addr = AW'(nxt2);
          idx_d   = AW'(nxt);
        end else begin
          count_d = count_q - CW'(1);
          state_d = S_DONE;
        end
      end

      S_SCAN: begin
        if (hit) begin
          res_pos_d   = idx_q;
          res_entry_d = rdata_q;
          state_d     = S_DONE;
        end else if (nxt < count_q) begin
          rd_en   = 1'b1;
          rd_addr = AW'(nxt);
          idx_d   = AW'(nxt);
        end else begin
          res_status_d = prq_pkg::StMiss;
          state_d      = S_DONE;
        end
      end

      S_DONE: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          status_d    = res_status_q;
          fpos_d      = pos_x[5:0];
          oid_d       = res_entry_q.id;
          octx_d      = res_entry_q.ctx;
          total_d     = cnt_x[6:0];
          nempty_d    = (count_q != '0);
          ohead_d     = (count_q != '0) ? head_q : '0;
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= '0;
      out_valid_q  <= 1'b0;
      req_q        <= prq_pkg::ReqEnq;
      pid_q        <= '0;
      ctx_q        <= '0;
      idx_q        <= '0;
      head_q       <= '0;
      res_status_q <= prq_pkg::StOk;
      res_pos_q    <= '0;
      res_entry_q  <= '0;
      status_q     <= '0;
      fpos_q       <= '0;
      oid_q        <= '0;
      octx_q       <= '0;
      total_q      <= '0;
      nempty_q     <= 1'b0;
      ohead_q      <= '0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      out_valid_q  <= out_valid_d;
      req_q        <= req_d;
      pid_q        <= pid_d;
      ctx_q        <= ctx_d;
      idx_q        <= idx_d;
      head_q       <= head_d;
      res_status_q <= res_status_d;
      res_pos_q    <= res_pos_d;
      res_entry_q  <= res_entry_d;
      status_q     <= status_d;
      fpos_q       <= fpos_d;
      oid_q        <= oid_d;
      octx_q       <= octx_d;
      total_q      <= total_d;
      nempty_q     <= nempty_d;
      ohead_q      <= ohead_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign found_position_o = fpos_q;
  assign out_id_o         = oid_q;
  assign out_context_o    = octx_q;
  assign entry_total_o    = total_q;
  assign not_empty_o      = nempty_q;
  assign head_id_o        = ohead_q;

  `PRQ_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CW'(DEPTH), "count exceeds depth")
  `PRQ_ASSERT_NEXT(a_count_step, 1'b1,
                   (count_q == $past(count_q)) || (count_q == $past(count_q) + CW'(1)) ||
                   (count_q + CW'(1) == $past(count_q)), "count moved by more than one")
  `PRQ_ASSERT_NEXT(a_busy_after_beat, in_fire, !in_ready_o, "accepted a beat while busy")

endmodule

`default_nettype wire
